### hw/rtl/simplex_noise_2d_grid_top_assert.svh
// Assertion macros shared by the simplex noise block.
// Depends on nothing; the including module provides clk and rst.
`ifndef SIMPLEX_NOISE_2D_GRID_TOP_ASSERT_SVH
`define SIMPLEX_NOISE_2D_GRID_TOP_ASSERT_SVH

// same-cycle implication
`define SNX_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define SNX_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### hw/rtl/snx_pkg.sv
// Types, constants and small functions of the simplex noise block.
// No dependencies.
package snx_pkg;

  localparam int TABLE_SIZE = 256;
  localparam int PERM_AW    = 8;
  localparam int IDX_W      = 16;
  localparam int ADDR_W     = 5;

  // skew (sqrt3-1)/2 and unskew (3-sqrt3)/6, 24 fraction bits
  localparam logic [22:0] SKEW_Q24   = 23'd6140887;
  localparam logic [21:0] UNSKEW_Q24 = 22'd3545443;

  localparam logic [2:0] REG_OFFSET_X  = 3'd0;
  localparam logic [2:0] REG_OFFSET_Y  = 3'd1;
  localparam logic [2:0] REG_SCALE_X   = 3'd2;
  localparam logic [2:0] REG_SCALE_Y   = 3'd3;
  localparam logic [2:0] REG_ORIGIN_X  = 3'd4;
  localparam logic [2:0] REG_ORIGIN_Y  = 3'd5;
  localparam logic [2:0] REG_AMPLITUDE = 3'd6;

  typedef struct packed {
    logic               smp;
    logic [7:0]         tidx;
    logic [7:0]         tval;
    logic [IDX_W-1:0]   col;
    logic [IDX_W-1:0]   row;
    logic signed [31:0] prior;
  } item_t;

  typedef struct packed {
    logic signed [31:0] offset_x;
    logic signed [31:0] offset_y;
    logic [31:0]        scale_x;
    logic [31:0]        scale_y;
    logic [23:0]        origin_x;
    logic [23:0]        origin_y;
    logic signed [31:0] amplitude;
  } cfg_t;

  // v mod 12 via reciprocal multiply, exact for 8-bit v
  function automatic logic [3:0] mod12(input logic [7:0] v);
    logic [15:0] p;
    logic [7:0]  q;
    logic [7:0]  r;
    p = 16'(v) * 16'd171;
    q = {3'b000, p[15:11]};
    r = v - 8'(q * 8'd12);
    return r[3:0];
  endfunction

  function automatic logic signed [1:0] grad_x(input logic [3:0] g);
    logic signed [1:0] r;
    unique case (g)
      4'd0, 4'd2, 4'd4, 4'd6: r = 2'sd1;
      4'd1, 4'd3, 4'd5, 4'd7: r = -2'sd1;
      default:                r = 2'sd0;
    endcase
    return r;
  endfunction

  function automatic logic signed [1:0] grad_y(input logic [3:0] g);
    logic signed [1:0] r;
    unique case (g)
      4'd0, 4'd1, 4'd8, 4'd10: r = 2'sd1;
      4'd2, 4'd3, 4'd9, 4'd11: r = -2'sd1;
      default:                 r = 2'sd0;
    endcase
    return r;
  endfunction

endpackage

### hw/rtl/simplex_noise_2d_grid_top.sv
// Top level of the 2D simplex noise grid sampler.
// Depends on snx_pkg, snx_front, snx_back, snx_fifo and the assertion header.
//
// Usage notes:
//  - Input channel (push/full): one word per cycle while full is low. func=0
//    writes table_value into permutation entry table_index; func=1 samples
//    noise at grid point (column,row) and adds it to prior_value.
//  - Result channel (empty/pop): one word per sample, none per load, in
//    input order; sum_value is valid while empty is low.
//  - A word leaves the input queue, passes the 21 back-end stages and then
//    enters the result queue. Throughput: one word per cycle, set by the
//    back-end pipeline, while the result queue has room.
//  - The five permutation reads of a sample hit three table copies,
//    so loads and samples may be freely interleaved.
//  - When the result queue fills the whole back end holds; the input queue
//    then fills and raises full. Nothing is dropped.
//  - Reset (rst, synchronous) empties both queues and loads the register
//    defaults (scale 1.0, gain 1.0, offsets and origin 0). The permutation
//    table is not cleared; it must be loaded before sampling.
//  - Write registers via APB-style port only while block is idle; unchecked.
module simplex_noise_2d_grid_top import snx_pkg::*; #(
  parameter int INDEX_BITS = 12
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  output logic                  full,
  input  logic                  func,
  input  logic [7:0]            table_index,
  input  logic [7:0]            table_value,
  input  logic [INDEX_BITS-1:0] column,
  input  logic [INDEX_BITS-1:0] row,
  input  logic signed [31:0]    prior_value,
  output logic                  empty,
  input  logic                  pop,
  output logic signed [31:0]    sum_value,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [ADDR_W-1:0]     paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready
);
  cfg_t               cfg;
  logic               cfg_wr;
  logic [2:0]         reg_sel;
  item_t              q_item;
  logic               q_empty;
  logic               q_pop;
  logic               res_push;
  logic signed [31:0] res_value;
  logic               oq_full;
  logic               back_adv;

  assign pready  = 1'b1;
  assign reg_sel = paddr[4:2];
  assign cfg_wr  = psel && penable && pwrite && pready;

  // register file; low address bits are ignored
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.offset_x  <= 32'sd0;
      cfg.offset_y  <= 32'sd0;
      cfg.scale_x   <= 32'd16777216;
      cfg.scale_y   <= 32'd16777216;
      cfg.origin_x  <= 24'd0;
      cfg.origin_y  <= 24'd0;
      cfg.amplitude <= 32'sd65536;
    end else if (cfg_wr && (paddr[1:0] == 2'b00 || paddr[1:0] != 2'b00)) begin
      unique case (reg_sel)
        REG_OFFSET_X:  cfg.offset_x  <= pwdata;
        REG_OFFSET_Y:  cfg.offset_y  <= pwdata;
        REG_SCALE_X:   cfg.scale_x   <= pwdata;
        REG_SCALE_Y:   cfg.scale_y   <= pwdata;
        REG_ORIGIN_X:  cfg.origin_x  <= pwdata[23:0];
        REG_ORIGIN_Y:  cfg.origin_y  <= pwdata[23:0];
        REG_AMPLITUDE: cfg.amplitude <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_OFFSET_X:  prdata = cfg.offset_x;
      REG_OFFSET_Y:  prdata = cfg.offset_y;
      REG_SCALE_X:   prdata = cfg.scale_x;
      REG_SCALE_Y:   prdata = cfg.scale_y;
      REG_ORIGIN_X:  prdata = {8'b0, cfg.origin_x};
      REG_ORIGIN_Y:  prdata = {8'b0, cfg.origin_y};
      REG_AMPLITUDE: prdata = cfg.amplitude;
      default:       prdata = 32'd0;
    endcase
  end

  snx_front #(.INDEX_BITS(INDEX_BITS)) u_front (
    .clk(clk), .rst(rst),
    .push(push), .full(full),
    .func(func), .table_index(table_index), .table_value(table_value),
    .column(column), .row(row), .prior_value(prior_value),
    .pop(q_pop), .item(q_item), .empty(q_empty)
  );

  snx_back u_back (
    .clk(clk), .rst(rst), .cfg(cfg),
    .item(q_item), .item_empty(q_empty), .item_pop(q_pop),
    .res_push(res_push), .res_value(res_value), .res_full(oq_full),
    .adv(back_adv)
  );

  // result queue decouples the back end from a stalling receiver
  snx_fifo #(.WIDTH(32), .DEPTH(4)) u_resq (
    .clk(clk), .rst(rst),
    .push(res_push), .wdata(res_value), .full(oq_full),
    .pop(pop), .rdata(sum_value), .empty(empty)
  );

`include "simplex_noise_2d_grid_top_assert.svh"

  `SNX_ASSERT_IMP(a_push_room, res_push, !oq_full, "result written into full queue")
  `SNX_ASSERT_IMP(a_stall_cause, !back_adv, oq_full && !q_pop, "back end held without cause")
  `SNX_ASSERT_NXT(a_gain_write, cfg_wr && reg_sel == REG_AMPLITUDE,
    cfg.amplitude == $past(pwdata), "gain register write lost")
endmodule

### hw/rtl/snx_fifo.sv
// Small synchronous queue with full and empty flags.
// No dependencies.
module snx_fifo #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);
  localparam int AW = $clog2(DEPTH);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [AW-1:0]    wp;
  logic [AW-1:0]    rp;
  logic [AW:0]      cnt;
  logic             do_push;
  logic             do_pop;

  assign full    = (cnt == (AW+1)'(DEPTH));
  assign empty   = (cnt == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem[rp];

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= '0;
      rp  <= '0;
      cnt <= '0;
    end else begin
      if (do_push) wp <= wp + 1'b1;
      if (do_pop) rp <= rp + 1'b1;
      if (do_push && !do_pop) cnt <= cnt + 1'b1;
      else if (do_pop && !do_push) cnt <= cnt - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) mem[wp] <= wdata;
  end
endmodule

### hw/rtl/snx_front.sv
// Front end: takes input words, tags load or sample, queues them.
// Depends on snx_pkg and snx_fifo.
module snx_front import snx_pkg::*; #(
  parameter int INDEX_BITS = 12
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  output logic                  full,
  input  logic                  func,
  input  logic [7:0]            table_index,
  input  logic [7:0]            table_value,
  input  logic [INDEX_BITS-1:0] column,
  input  logic [INDEX_BITS-1:0] row,
  input  logic signed [31:0]    prior_value,
  input  logic                  pop,
  output item_t                 item,
  output logic                  empty
);
  item_t in_item;

  always_comb begin
    in_item.smp   = func;
    in_item.tidx  = table_index;
    in_item.tval  = table_value;
    in_item.col   = IDX_W'(column);
    in_item.row   = IDX_W'(row);
    in_item.prior = prior_value;
  end

  snx_fifo #(.WIDTH($bits(item_t)), .DEPTH(4)) u_q (
    .clk(clk), .rst(rst),
    .push(push), .wdata(in_item), .full(full),
    .pop(pop), .rdata(item), .empty(empty)
  );
endmodule

### hw/rtl/snx_corner.sv
// One corner contribution: radial falloff to the fourth times gradient dot.
// Depends on snx_pkg. Five register stages, all held when adv is low.
module snx_corner import snx_pkg::*; (
  input  logic               clk,
  input  logic               adv,
  input  logic signed [31:0] dx,
  input  logic signed [31:0] dy,
  input  logic [3:0]         g,
  output logic signed [31:0] c
);
  logic signed [63:0] sqx, sqy;
  logic signed [1:0]  gx, gy;
  logic signed [31:0] dx1, dy1;
  logic               pos2, pos3, pos4;
  logic [22:0]        t24;
  logic [21:0]        t2;
  logic [19:0]        t4;
  logic signed [33:0] dot2, dot3, dot4;
  logic signed [65:0] t_c;
  logic signed [33:0] px, py;
  logic [45:0]        sq_a;
  logic [43:0]        sq_b;
  logic signed [54:0] prod;

  always_comb begin
    t_c = 66'sd1 <<< 47;
    t_c = t_c - 66'(sqx) - 66'(sqy);
    px = (gx == 2'sd1) ? 34'(dx1) : ((gx == -2'sd1) ? -34'(dx1) : 34'sd0);
    py = (gy == 2'sd1) ? 34'(dy1) : ((gy == -2'sd1) ? -34'(dy1) : 34'sd0);
    sq_a = 46'(t24) * 46'(t24);
    sq_b = 44'(t2) * 44'(t2);
    prod = 55'($signed({1'b0, t4})) * 55'(dot4);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sqx  <= 64'(dx) * 64'(dx);
      sqy  <= 64'(dy) * 64'(dy);
      gx   <= grad_x(g);
      gy   <= grad_y(g);
      dx1  <= dx;
      dy1  <= dy;
      pos2 <= (t_c > 66'sd0);
      t24  <= t_c[46:24];
      dot2 <= px + py;
      pos3 <= pos2;
      t2   <= sq_a[45:24];
      dot3 <= dot2;
      pos4 <= pos3;
      t4   <= sq_b[43:24];
      dot4 <= dot3;
      c    <= pos4 ? 32'(prod >>> 24) : 32'sd0;
    end
  end
endmodule

### hw/rtl/snx_back.sv
// Back end: position, skew, table lookups, corners, gain and saturation.
// Depends on snx_pkg and snx_corner. 21 stages; one item per cycle when adv.
module snx_back import snx_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  cfg_t               cfg,
  input  item_t              item,
  input  logic               item_empty,
  output logic               item_pop,
  output logic               res_push,
  output logic signed [31:0] res_value,
  input  logic               res_full,
  output logic               adv
);
  localparam int NS = 21;
  localparam logic signed [31:0] ONE = 32'sd16777216;

  logic          vld [1:NS];
  logic          smp [1:NS];
  logic signed [31:0] pri [1:NS];
  logic [7:0]    tix [1:8];
  logic [7:0]    tvl [1:8];

  logic [7:0] mem_a [TABLE_SIZE];
  logic [7:0] mem_b [TABLE_SIZE];
  logic [7:0] mem_c [TABLE_SIZE];

  logic signed [34:0] ax, ay;
  logic signed [51:0] mxh, mxl, myh, myl;
  logic signed [51:0] x3, y3, x4, y4, x5, y5, x6, y6, x7, y7, x8, y8;
  logic signed [52:0] s4, ph, skew;
  logic [46:0]        pl;
  logic signed [29:0] x0_7, y0_7, x0_8, y0_8;
  logic signed [53:0] unsk;
  logic signed [53:0] sumx_c, sumy_c;
  logic signed [55:0] dxw, dyw;
  logic signed [31:0] dx0_9, dy0_9;
  logic [7:0]         ii9, pa0, pa1;
  logic               ci;
  logic [7:0]         a0, a1, a2;
  logic signed [31:0] d10 [6];
  logic signed [31:0] d11 [6];
  logic [7:0]         gd0, gd1, gd2;
  logic [3:0]         g0, g1, g2;
  logic signed [31:0] c0, c1, c2;
  logic signed [33:0] n17;
  logic signed [39:0] noise;
  logic signed [56:0] plo;
  logic signed [55:0] phi;
  logic signed [72:0] prod;
  logic signed [49:0] sum_w;
  logic signed [31:0] sum21;

  assign adv       = !(vld[NS] && smp[NS] && res_full);
  assign item_pop  = adv && !item_empty;
  assign res_push  = vld[NS] && smp[NS] && !res_full;
  assign res_value = sum21;

  always_comb begin
    sumx_c = (54'(x6) + 54'(skew)) >>> 24;
    sumy_c = (54'(y6) + 54'(skew)) >>> 24;
    dxw = 56'(x8) - 56'($signed({x0_8, 24'b0})) + 56'(unsk);
    dyw = 56'(y8) - 56'($signed({y0_8, 24'b0})) + 56'(unsk);
    ci  = (dx0_9 > dy0_9);
    a0  = ii9 + pa0;
    a1  = ii9 + {7'b0, ci} + (ci ? pa0 : pa1);
    a2  = ii9 + 8'd1 + pa1;
    sum_w = 50'(pri[NS-1]) + 50'(prod >>> 24);
  end

  // valid and tag pipeline
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 1; k <= NS; k++) vld[k] <= 1'b0;
    end else if (adv) begin
      vld[1] <= !item_empty;
      for (int k = 2; k <= NS; k++) vld[k] <= vld[k-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      smp[1] <= item.smp;
      pri[1] <= item.prior;
      tix[1] <= item.tidx;
      tvl[1] <= item.tval;
      for (int k = 2; k <= NS; k++) begin
        smp[k] <= smp[k-1];
        pri[k] <= pri[k-1];
      end
      for (int k = 2; k <= 8; k++) begin
        tix[k] <= tix[k-1];
        tvl[k] <= tvl[k-1];
      end
    end
  end

  // permutation table copies; loads write while a sample does its first read
  always_ff @(posedge clk) begin
    if (adv) begin
      if (vld[8] && !smp[8]) begin
        mem_a[tix[8]] <= tvl[8];
        mem_b[tix[8]] <= tvl[8];
        mem_c[tix[8]] <= tvl[8];
      end
      pa0 <= mem_a[y0_8[7:0]];
      pa1 <= mem_a[y0_8[7:0] + 8'd1];
      gd0 <= mem_b[a0];
      gd1 <= mem_b[a1];
      gd2 <= mem_c[a2];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ax  <= 35'(cfg.offset_x) + $signed({3'b0, item.col, 16'b0});
      ay  <= 35'(cfg.offset_y) + $signed({3'b0, item.row, 16'b0});
      mxh <= 52'(ax) * 52'($signed({1'b0, cfg.scale_x[31:16]}));
      mxl <= 52'(ax) * 52'($signed({1'b0, cfg.scale_x[15:0]}));
      myh <= 52'(ay) * 52'($signed({1'b0, cfg.scale_y[31:16]}));
      myl <= 52'(ay) * 52'($signed({1'b0, cfg.scale_y[15:0]}));
      x3  <= mxh + (mxl >>> 16) + $signed({20'b0, cfg.origin_x, 8'b0});
      y3  <= myh + (myl >>> 16) + $signed({20'b0, cfg.origin_y, 8'b0});
      s4  <= 53'(x3) + 53'(y3);
      x4  <= x3;
      y4  <= y3;
      ph  <= 53'($signed(s4[52:24])) * 53'($signed({1'b0, SKEW_Q24}));
      pl  <= 47'(s4[23:0]) * 47'(SKEW_Q24);
      x5  <= x4;
      y5  <= y4;
      skew <= ph + $signed({30'b0, pl[46:24]});
      x6  <= x5;
      y6  <= y5;
      x7  <= x6;
      y7  <= y6;
      x0_7 <= sumx_c[29:0];
      y0_7 <= sumy_c[29:0];
      unsk <= 54'(31'(x0_7) + 31'(y0_7)) * 54'($signed({1'b0, UNSKEW_Q24}));
      x8   <= x7;
      y8   <= y7;
      x0_8 <= x0_7;
      y0_8 <= y0_7;
      dx0_9 <= dxw[31:0];
      dy0_9 <= dyw[31:0];
      ii9   <= x0_8[7:0];
      d10[0] <= dx0_9;
      d10[1] <= dy0_9;
      d10[2] <= dx0_9 - (ci ? ONE : 32'sd0) + 32'(UNSKEW_Q24);
      d10[3] <= dy0_9 - (ci ? 32'sd0 : ONE) + 32'(UNSKEW_Q24);
      d10[4] <= dx0_9 - ONE + 32'({UNSKEW_Q24, 1'b0});
      d10[5] <= dy0_9 - ONE + 32'({UNSKEW_Q24, 1'b0});
      for (int k = 0; k < 6; k++) d11[k] <= d10[k];
      g0 <= mod12(gd0);
      g1 <= mod12(gd1);
      g2 <= mod12(gd2);
      n17   <= 34'(c0) + 34'(c1) + 34'(c2);
      noise <= 40'(n17) * 40'sd70;
      plo   <= 57'(noise) * 57'($signed({1'b0, cfg.amplitude[15:0]}));
      phi   <= 56'(noise) * 56'($signed(cfg.amplitude[31:16]));
      prod  <= (73'(phi) <<< 16) + 73'(plo);
      if (sum_w > 50'sd2147483647) sum21 <= 32'sh7fffffff;
      else if (sum_w < -50'sd2147483648) sum21 <= 32'sh80000000;
      else sum21 <= sum_w[31:0];
    end
  end

  snx_corner u_c0 (.clk(clk), .adv(adv), .dx(d11[0]), .dy(d11[1]), .g(g0), .c(c0));
  snx_corner u_c1 (.clk(clk), .adv(adv), .dx(d11[2]), .dy(d11[3]), .g(g1), .c(c1));
  snx_corner u_c2 (.clk(clk), .adv(adv), .dx(d11[4]), .dy(d11[5]), .g(g2), .c(c2));
endmodule

### sim/simplex_noise_2d_grid_top_tb.sv
// Self-checking testbench for simplex_noise_2d_grid_top: table loads, directed and random
// samples, register sweeps. Depends on snx_pkg and the RTL of the block only.
module simplex_noise_2d_grid_top_tb import snx_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic       FUNC_LOAD   = 1'b0;
  localparam logic       FUNC_SAMPLE = 1'b1;
  localparam logic [2:0] REG_NONE    = 3'd7;   // no register here, write must be ignored
  localparam int         LIMIT       = 400000;
  localparam int         SETTLE      = 40;     // covers the back-end pipeline

  typedef enum logic [1:0] {ROW_CFG, ROW_LOAD, ROW_SAMPLE} row_kind_t;
  typedef struct {
    row_kind_t   kind;
    logic [2:0]  ridx;
    logic [31:0] val;
    logic [11:0] col;
    logic [11:0] row;
    logic [31:0] prior;
    bit          fixed;     // expected word typed in below
    logic [31:0] fixed_val;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic push = 1'b0, func = 1'b0, pop = 1'b0;
  logic [7:0] table_index = '0, table_value = '0;
  logic [11:0] column = '0, row = '0;
  logic signed [31:0] prior_value = '0;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic full, empty, pready;
  logic signed [31:0] sum_value;
  logic [31:0] prdata;

  simplex_noise_2d_grid_top dut (.*);

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // ---- shadow of the block: registers and permutation table ----
  cfg_t        shadow_cfg;
  logic [7:0]  shadow_perm [TABLE_SIZE];
  logic [31:0] sums_due [$];
  int          n_err = 0, n_loads = 0, n_samples = 0, n_checked = 0, n_cfg = 0;
  bit          steady = 1'b0;   // no idling on either side while set

  const int grad_x_tab [12] = '{1, -1, 1, -1, 1, -1, 1, -1, 0, 0, 0, 0};
  const int grad_y_tab [12] = '{1, 1, -1, -1, 0, 0, 0, 0, 1, -1, 1, -1};

  // Q24 position on one axis: (offset + idx) * scale + origin
  function automatic longint axis_q24(longint off, longint scale, longint orig, longint idx);
    longint a;
    a = off + (idx <<< 16);
    return a * (scale >>> 16) + ((a * (scale & 64'sd65535)) >>> 16) + (orig <<< 8);
  endfunction

  function automatic longint mul_frac24(longint s, longint c);
    longint sh;
    sh = s >>> 24;
    return sh * c + (((s - (sh <<< 24)) * c) >>> 24);
  endfunction

  // one corner's falloff^4 times the gradient dot product
  function automatic longint corner_q24(longint dx, longint dy, int g);
    longint t;
    t = (64'sd1 <<< 47) - dx * dx - dy * dy;
    if (t <= 0) return 0;
    t = t >>> 24;
    t = (t * t) >>> 24;
    t = (t * t) >>> 24;
    return (t * (grad_x_tab[g] * dx + grad_y_tab[g] * dy)) >>> 24;
  endfunction

  function automatic logic [31:0] noisy_sum(logic [11:0] c, logic [11:0] r, logic [31:0] prior);
    longint x, y, skew, x0, y0, unsk, dx0, dy0, dx1, dy1, dx2, dy2, ci, cj, noise, s;
    int ii, jj, g0, g1, g2;
    x = axis_q24(longint'(shadow_cfg.offset_x), longint'(shadow_cfg.scale_x),
                 longint'(shadow_cfg.origin_x), longint'(c));
    y = axis_q24(longint'(shadow_cfg.offset_y), longint'(shadow_cfg.scale_y),
                 longint'(shadow_cfg.origin_y), longint'(r));
    skew = mul_frac24(x + y, longint'(SKEW_Q24));
    x0 = (x + skew) >>> 24;
    y0 = (y + skew) >>> 24;
    unsk = (x0 + y0) * longint'(UNSKEW_Q24);
    dx0 = x - ((x0 <<< 24) - unsk);
    dy0 = y - ((y0 <<< 24) - unsk);
    ci = (dx0 > dy0) ? 1 : 0;          // lower or upper triangle
    cj = 1 - ci;
    dx1 = dx0 - (ci <<< 24) + longint'(UNSKEW_Q24);
    dy1 = dy0 - (cj <<< 24) + longint'(UNSKEW_Q24);
    dx2 = dx0 - (64'sd1 <<< 24) + 2 * longint'(UNSKEW_Q24);
    dy2 = dy0 - (64'sd1 <<< 24) + 2 * longint'(UNSKEW_Q24);
    ii = int'(x0 & 255);
    jj = int'(y0 & 255);
    g0 = shadow_perm[(ii + shadow_perm[jj]) & 255] % 12;
    g1 = shadow_perm[(ii + ci + shadow_perm[(jj + cj) & 255]) & 255] % 12;
    g2 = shadow_perm[(ii + 1 + shadow_perm[(jj + 1) & 255]) & 255] % 12;
    noise = 70 * (corner_q24(dx0, dy0, g0) + corner_q24(dx1, dy1, g1) + corner_q24(dx2, dy2, g2));
    s = longint'(signed'(prior)) + ((noise * longint'(shadow_cfg.amplitude)) >>> 24);
    if (s > 64'sd2147483647) s = 64'sd2147483647;
    if (s < -64'sd2147483648) s = -64'sd2147483648;
    return s[31:0];
  endfunction

  // ---- input side: hold the word until it is taken ----
  task automatic send_word(logic f, logic [7:0] ti, logic [7:0] tv, logic [11:0] c,
                           logic [11:0] r, logic [31:0] prior, bit fixed, logic [31:0] fv);
    while (!steady && $urandom_range(99) < 18) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push <= 1'b1;
    func <= f; table_index <= ti; table_value <= tv;
    column <= c; row <= r; prior_value <= prior;
    do @(posedge clk); while (full);
    if (f == FUNC_LOAD) begin
      shadow_perm[ti] = tv;
      n_loads++;
    end else begin
      sums_due.push_back(fixed ? fv : noisy_sum(c, r, prior));
      n_samples++;
    end
  endtask

  // wait until the block is idle, then write one register over APB
  task automatic write_reg(logic [2:0] ridx, logic [31:0] v);
    push <= 1'b0;
    while (sums_due.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);   // loads in flight give no result
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= {ridx, 2'b00}; pwdata <= v;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    case (ridx)
      REG_OFFSET_X:  shadow_cfg.offset_x  = v;
      REG_OFFSET_Y:  shadow_cfg.offset_y  = v;
      REG_SCALE_X:   shadow_cfg.scale_x   = v;
      REG_SCALE_Y:   shadow_cfg.scale_y   = v;
      REG_ORIGIN_X:  shadow_cfg.origin_x  = v[23:0];
      REG_ORIGIN_Y:  shadow_cfg.origin_y  = v[23:0];
      REG_AMPLITUDE: shadow_cfg.amplitude = v;
      default: ;
    endcase
    n_cfg++;
  endtask

  function automatic stim_row_t mk(row_kind_t k, logic [2:0] ri, logic [31:0] v,
                                   logic [11:0] c, logic [11:0] r, logic [31:0] p,
                                   bit fx, logic [31:0] fv);
    stim_row_t s;
    s = '{k, ri, v, c, r, p, fx, fv};
    return s;
  endfunction

  // random register value, extremes a quarter of the time
  function automatic logic [31:0] pick_reg(logic [31:0] lo, logic [31:0] hi);
    int k;
    k = $urandom_range(7);
    return (k == 0) ? lo : (k == 1) ? hi : $urandom();
  endfunction

  // ---- result side: random pop, check against the oldest prediction ----
  always @(posedge clk) begin
    if (!rst && pop && !empty) begin
      if (sums_due.size() == 0) begin
        $error("sum_value: unexpected word %0d", sum_value);
        n_err++;
      end else begin
        if (sum_value !== sums_due[0]) begin
          $error("sum_value: expected %0d actual %0d", signed'(sums_due[0]), sum_value);
          n_err++;
        end
        void'(sums_due.pop_front());
        n_checked++;
      end
    end
    pop <= steady || ($urandom_range(99) >= 18);
  end

  int cycles = 0;
  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("simplex_noise_2d_grid_top_tb failed");
      $finish;
    end
  end

  stim_row_t dir_rows [$];

  initial begin
    shadow_cfg = '{32'sd0, 32'sd0, 32'd16777216, 32'd16777216, 24'd0, 24'd0, 32'sd65536};
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // every sample must read written entries, so fill the whole table first
    for (int i = 0; i < TABLE_SIZE; i++)
      send_word(FUNC_LOAD, 8'(i), 8'($urandom()), '0, '0, '0, 1'b0, '0);

    // directed part: gain 0 passes the prior through, then extremes of everything
    dir_rows.push_back(mk(ROW_CFG, REG_AMPLITUDE, 32'd0, 0, 0, 0, 0, 0));
    dir_rows.push_back(mk(ROW_SAMPLE, 0, 0, 12'd0, 12'd0, 32'd0, 1, 32'd0));
    dir_rows.push_back(mk(ROW_SAMPLE, 0, 0, 12'hFFF, 12'hFFF, 32'h7FFFFFFF, 1, 32'h7FFFFFFF));
    dir_rows.push_back(mk(ROW_SAMPLE, 0, 0, 12'd0, 12'hFFF, 32'h80000000, 1, 32'h80000000));
    dir_rows.push_back(mk(ROW_CFG, REG_NONE, 32'h00012345, 0, 0, 0, 0, 0));
    dir_rows.push_back(mk(ROW_SAMPLE, 0, 0, 12'd123, 12'd45, 32'd5, 1, 32'd5));
    dir_rows.push_back(mk(ROW_CFG, REG_AMPLITUDE, 32'd65536, 0, 0, 0, 0, 0));
    dir_rows.push_back(mk(ROW_LOAD, 0, 32'h0000FF00, 0, 0, 0, 0, 0));    // entry 0 <- 255
    dir_rows.push_back(mk(ROW_LOAD, 0, 32'h0000FF00 ^ 32'hFFFF, 0, 0, 0, 0, 0));
    dir_rows.push_back(mk(ROW_SAMPLE, 0, 0, 12'd0, 12'd0, 32'd0, 0, 0));
    dir_rows.push_back(mk(ROW_SAMPLE, 0, 0, 12'hFFF, 12'd0, 32'h7FFFFFFF, 0, 0));
    dir_rows.push_back(mk(ROW_CFG, REG_AMPLITUDE, 32'h7FFFFFFF, 0, 0, 0, 0, 0));
    dir_rows.push_back(mk(ROW_SAMPLE, 0, 0, 12'd17, 12'd300, 32'h80000000, 0, 0));
    dir_rows.push_back(mk(ROW_SAMPLE, 0, 0, 12'd1, 12'd2, 32'h7FFFFFFF, 0, 0));
    dir_rows.push_back(mk(ROW_CFG, REG_AMPLITUDE, 32'h80000000, 0, 0, 0, 0, 0));
    dir_rows.push_back(mk(ROW_SAMPLE, 0, 0, 12'd5, 12'd5, 32'd0, 0, 0));
    dir_rows.push_back(mk(ROW_CFG, REG_SCALE_X, 32'hFFFFFFFF, 0, 0, 0, 0, 0));
    dir_rows.push_back(mk(ROW_CFG, REG_SCALE_Y, 32'd0, 0, 0, 0, 0, 0));
    dir_rows.push_back(mk(ROW_CFG, REG_OFFSET_X, 32'h80000000, 0, 0, 0, 0, 0));
    dir_rows.push_back(mk(ROW_CFG, REG_OFFSET_Y, 32'h7FFFFFFF, 0, 0, 0, 0, 0));
    dir_rows.push_back(mk(ROW_CFG, REG_ORIGIN_X, 32'h00FFFFFF, 0, 0, 0, 0, 0));
    dir_rows.push_back(mk(ROW_CFG, REG_ORIGIN_Y, 32'd0, 0, 0, 0, 0, 0));
    dir_rows.push_back(mk(ROW_SAMPLE, 0, 0, 12'hFFF, 12'hFFF, 32'd0, 0, 0));
    dir_rows.push_back(mk(ROW_SAMPLE, 0, 0, 12'd0, 12'd0, 32'hFFFF0000, 0, 0));

    // load rows carry index in val[7:0] and value in val[15:8]
    foreach (dir_rows[i]) begin
      case (dir_rows[i].kind)
        ROW_CFG:  write_reg(dir_rows[i].ridx, dir_rows[i].val);
        ROW_LOAD: send_word(FUNC_LOAD, dir_rows[i].val[7:0], dir_rows[i].val[15:8],
                            '0, '0, '0, 1'b0, '0);
        default:  send_word(FUNC_SAMPLE, '0, '0, dir_rows[i].col, dir_rows[i].row,
                            dir_rows[i].prior, dir_rows[i].fixed, dir_rows[i].fixed_val);
      endcase
    end

    // random phases, a fresh register setting before each
    for (int ph = 0; ph < 10; ph++) begin
      write_reg(REG_OFFSET_X, pick_reg(32'h80000000, 32'h7FFFFFFF));
      write_reg(REG_OFFSET_Y, pick_reg(32'h80000000, 32'h7FFFFFFF));
      write_reg(REG_SCALE_X, pick_reg(32'd0, 32'hFFFFFFFF));
      write_reg(REG_SCALE_Y, pick_reg(32'd0, 32'hFFFFFFFF));
      write_reg(REG_ORIGIN_X, pick_reg(32'd0, 32'h00FFFFFF) & 32'h00FFFFFF);
      write_reg(REG_ORIGIN_Y, pick_reg(32'd0, 32'h00FFFFFF) & 32'h00FFFFFF);
      write_reg(REG_AMPLITUDE, (ph % 3 == 0) ? 32'd65536 : pick_reg(32'h80000000, 32'h7FFFFFFF));
      steady = (ph == 3);
      for (int k = 0; k < 90; k++) begin
        if ($urandom_range(99) < 15)
          send_word(FUNC_LOAD, 8'($urandom()), 8'($urandom()), '0, '0, '0, 1'b0, '0);
        else
          send_word(FUNC_SAMPLE, '0, '0, 12'($urandom()), 12'($urandom()), $urandom(),
                    1'b0, '0);
      end
      steady = 1'b0;
    end

    push <= 1'b0;
    while (sums_due.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    $display("covered %0d table loads, %0d samples (%0d words checked), %0d register writes",
             n_loads, n_samples, n_checked, n_cfg);
    if (n_err == 0)
      $display("simplex_noise_2d_grid_top_tb passed");
    else
      $display("simplex_noise_2d_grid_top_tb failed");
    $finish;
  end

endmodule
